[rtl/core/pet_pkg.sv]
package pet_pkg;

	localparam int MAX_VERTICES = 256;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int COORD_BITS   = 24;
	localparam int DELTA_W      = COORD_BITS + 1;
	localparam int BOX_W        = COORD_BITS + 2;
	localparam int PROD_W       = 2 * DELTA_W;
	localparam int CROSS_W      = PROD_W + 1;
	localparam int APROD_W      = 2 * COORD_BITS;
	localparam int AREA_W       = 57;
	localparam int EPS_W        = 24;
	localparam int MARGIN_W     = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VERTEX_COUNT = 2'd0,
		CFG_CROSS_EPS    = 2'd1,
		CFG_COORD_EPS    = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_QUERY = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t                     kind;
		logic [VIDX_W-1:0]             idx;
		logic signed [COORD_BITS-1:0]  x;
		logic signed [COORD_BITS-1:0]  y;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0]    count;
		logic [EPS_W-1:0]    cross_eps;
		logic [MARGIN_W-1:0] coord_eps;
	} cfg_t;

endpackage

[rtl/core/pet_front.sv]
module pet_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  pet_pkg::req_t  in_req,
	output logic           q_valid,
	output pet_pkg::req_t  q_req,
	input  logic           q_pop
);
	import pet_pkg::*;

	req_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;

	assign in_stall = (fill_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (fill_q != 2'd0);
	assign q_req    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

[rtl/core/pet_back.sv]
module pet_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pet_pkg::cfg_t                        cfg,
	input  logic                                 q_valid,
	input  pet_pkg::req_t                        q_req,
	output logic                                 q_pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 is_ear,
	output logic signed [pet_pkg::AREA_W-1:0]    twice_area,
	output logic                                 index_error
);
	import pet_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_TRI, ST_SETUP, ST_SWEEP, ST_DRAIN, ST_DONE
	} state_t;

	state_t state_q;

	logic signed [COORD_BITS-1:0] mem_x_q [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] mem_y_q [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] rd_x_q, rd_y_q;
	logic [VIDX_W-1:0]            rd_addr;

	logic [CNT_W-1:0]  n_q, cnt_q;
	logic [VIDX_W-1:0] idx_q, pv_q, nx_q;
	logic              err_q;

	logic signed [COORD_BITS-1:0] pvx_q, pvy_q, ix_q, iy_q, nxx_q, nxy_q;
	logic signed [COORD_BITS-1:0] v0x_q, v0y_q, prev_x_q, prev_y_q;
	logic signed [DELTA_W-1:0]    e1x_q, e1y_q, e2x_q, e2y_q, e3x_q, e3y_q;
	logic signed [BOX_W-1:0]      lox_q, hix_q, loy_q, hiy_q;
	logic signed [AREA_W-1:0]     acc_q;
	logic signed [CROSS_W-1:0]    tri_cross_q;
	logic                         blocked_q;

	// pipeline of the sweep
	logic              v_s1, wrap_s1;
	logic [VIDX_W-1:0] idx_s1;

	logic v_s2, test_s2, skip_s2, inbox_s2, nxhit_s2, aen_s2;
	logic signed [DELTA_W-1:0]    dpx_s2, dpy_s2, dix_s2, diy_s2, dnx_s2, dny_s2;
	logic signed [COORD_BITS-1:0] ax_s2, ay_s2, bx_s2, by_s2;

	logic v_s3, test_s3, skip_s3, inbox_s3, nxhit_s3, aen_s3;
	logic signed [PROD_W-1:0]  p1a_s3, p1b_s3, p2a_s3, p2b_s3, p3a_s3, p3b_s3;
	logic signed [APROD_W-1:0] pa_s3, pb_s3;

	// combinational helpers
	logic [CNT_W-1:0]             n_new, ip1;
	logic [VIDX_W-1:0]            pv_new, nx_new;
	logic signed [COORD_BITS-1:0] cur_x, cur_y;
	logic signed [CROSS_W-1:0]    c1, c2, c3, eps_pos, eps_neg;
	logic signed [APROD_W:0]      aterm;
	logic signed [BOX_W-1:0]      margin;

	function automatic logic signed [COORD_BITS-1:0] min3(
		input logic signed [COORD_BITS-1:0] a, b, c);
		logic signed [COORD_BITS-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] max3(
		input logic signed [COORD_BITS-1:0] a, b, c);
		logic signed [COORD_BITS-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	assign n_new  = (cfg.count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : cfg.count;
	assign ip1    = {1'b0, q_req.idx} + CNT_W'(1);
	assign pv_new = (q_req.idx == '0) ? VIDX_W'(n_new - CNT_W'(1)) : VIDX_W'(ip1 - CNT_W'(2));
	assign nx_new = (ip1 == n_new) ? '0 : ip1[VIDX_W-1:0];

	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign margin = $signed({{(BOX_W-MARGIN_W){1'b0}}, cfg.coord_eps});

	assign eps_pos = $signed({{(CROSS_W-EPS_W){1'b0}}, cfg.cross_eps});
	assign eps_neg = -eps_pos;

	assign cur_x = wrap_s1 ? v0x_q : rd_x_q;
	assign cur_y = wrap_s1 ? v0y_q : rd_y_q;

	assign c1    = CROSS_W'(p1a_s3) - CROSS_W'(p1b_s3);
	assign c2    = CROSS_W'(p2a_s3) - CROSS_W'(p2b_s3);
	assign c3    = CROSS_W'(p3a_s3) - CROSS_W'(p3b_s3);
	assign aterm = (APROD_W+1)'(pa_s3) - (APROD_W+1)'(pb_s3);

	always_comb begin
		rd_addr = idx_q;
		if (state_q == ST_TRI) begin
			case (cnt_q[1:0])
				2'd0:    rd_addr = pv_q;
				2'd2:    rd_addr = nx_q;
				default: rd_addr = idx_q;
			endcase
		end else if (state_q == ST_SWEEP) begin
			rd_addr = cnt_q[VIDX_W-1:0];
		end
	end

	// vertex store: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (q_pop && q_req.kind == REQ_WRITE) begin
			mem_x_q[q_req.idx] <= q_req.x;
			mem_y_q[q_req.idx] <= q_req.y;
		end
		rd_x_q <= mem_x_q[rd_addr];
		rd_y_q <= mem_y_q[rd_addr];
	end

	// datapath of the sweep
	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		if (v_s1) begin
			dpx_s2   <= DELTA_W'(cur_x) - DELTA_W'(pvx_q);
			dpy_s2   <= DELTA_W'(cur_y) - DELTA_W'(pvy_q);
			dix_s2   <= DELTA_W'(cur_x) - DELTA_W'(ix_q);
			diy_s2   <= DELTA_W'(cur_y) - DELTA_W'(iy_q);
			dnx_s2   <= DELTA_W'(cur_x) - DELTA_W'(nxx_q);
			dny_s2   <= DELTA_W'(cur_y) - DELTA_W'(nxy_q);
			inbox_s2 <= (BOX_W'(cur_x) >= lox_q) && (BOX_W'(cur_x) <= hix_q) &&
				(BOX_W'(cur_y) >= loy_q) && (BOX_W'(cur_y) <= hiy_q);
			skip_s2  <= (idx_s1 == idx_q) || (idx_s1 == pv_q) || (idx_s1 == nx_q);
			nxhit_s2 <= !wrap_s1 && (idx_s1 == nx_q);
			test_s2  <= !wrap_s1;
			aen_s2   <= wrap_s1 || (idx_s1 != '0);
			ax_s2    <= prev_x_q;
			ay_s2    <= prev_y_q;
			bx_s2    <= cur_x;
			by_s2    <= cur_y;
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
			if (!wrap_s1 && idx_s1 == '0) begin
				v0x_q <= cur_x;
				v0y_q <= cur_y;
			end
		end
		if (v_s2) begin
			p1a_s3   <= e1x_q * dpy_s2;
			p1b_s3   <= e1y_q * dpx_s2;
			p2a_s3   <= e2x_q * diy_s2;
			p2b_s3   <= e2y_q * dix_s2;
			p3a_s3   <= e3x_q * dny_s2;
			p3b_s3   <= e3y_q * dnx_s2;
			pa_s3    <= ax_s2 * by_s2;
			pb_s3    <= ay_s2 * bx_s2;
			test_s3  <= test_s2;
			skip_s3  <= skip_s2;
			inbox_s3 <= inbox_s2;
			nxhit_s3 <= nxhit_s2;
			aen_s3   <= aen_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			v_s1        <= 1'b0;
			wrap_s1     <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid   <= 1'b0;
			cnt_q       <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			pv_q        <= '0;
			nx_q        <= '0;
			err_q       <= 1'b0;
			acc_q       <= '0;
			tri_cross_q <= '0;
			blocked_q   <= 1'b0;
			is_ear      <= 1'b0;
			twice_area  <= '0;
			index_error <= 1'b0;
		end else begin
			v_s1    <= 1'b0;
			wrap_s1 <= 1'b0;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			if (out_valid && !out_stall && state_q != ST_DONE) begin
				out_valid <= 1'b0;
			end
			if (v_s3) begin
				if (nxhit_s3) begin
					tri_cross_q <= c1;
				end
				if (test_s3 && !skip_s3 && inbox_s3 &&
					c1 >= eps_neg && c2 >= eps_neg && c3 >= eps_neg) begin
					blocked_q <= 1'b1;
				end
				if (aen_s3) begin
					acc_q <= acc_q + AREA_W'(aterm);
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && q_req.kind == REQ_QUERY) begin
						n_q         <= n_new;
						idx_q       <= q_req.idx;
						pv_q        <= pv_new;
						nx_q        <= nx_new;
						err_q       <= ({1'b0, q_req.idx} >= n_new);
						acc_q       <= '0;
						tri_cross_q <= '0;
						blocked_q   <= 1'b0;
						cnt_q       <= '0;
						state_q     <= (n_new == '0) ? ST_DRAIN : ST_TRI;
					end
				end
				ST_TRI: begin
					cnt_q <= cnt_q + CNT_W'(1);
					case (cnt_q[1:0])
						2'd1: begin
							pvx_q <= rd_x_q;
							pvy_q <= rd_y_q;
						end
						2'd2: begin
							ix_q <= rd_x_q;
							iy_q <= rd_y_q;
						end
						2'd3: begin
							nxx_q   <= rd_x_q;
							nxy_q   <= rd_y_q;
							state_q <= ST_SETUP;
						end
						default: ;
					endcase
				end
				ST_SETUP: begin
					e1x_q   <= DELTA_W'(ix_q) - DELTA_W'(pvx_q);
					e1y_q   <= DELTA_W'(iy_q) - DELTA_W'(pvy_q);
					e2x_q   <= DELTA_W'(nxx_q) - DELTA_W'(ix_q);
					e2y_q   <= DELTA_W'(nxy_q) - DELTA_W'(iy_q);
					e3x_q   <= DELTA_W'(pvx_q) - DELTA_W'(nxx_q);
					e3y_q   <= DELTA_W'(pvy_q) - DELTA_W'(nxy_q);
					lox_q   <= BOX_W'(min3(pvx_q, ix_q, nxx_q)) - margin;
					hix_q   <= BOX_W'(max3(pvx_q, ix_q, nxx_q)) + margin;
					loy_q   <= BOX_W'(min3(pvy_q, iy_q, nxy_q)) - margin;
					hiy_q   <= BOX_W'(max3(pvy_q, iy_q, nxy_q)) + margin;
					cnt_q   <= '0;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					v_s1 <= 1'b1;
					if (cnt_q == n_q) begin
						wrap_s1 <= 1'b1;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid   <= 1'b1;
						is_ear      <= !err_q && (tri_cross_q > eps_pos) && !blocked_q;
						twice_area  <= acc_q;
						index_error <= err_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/polygon_ear_test_unit.sv]
// Ear test over a stored polygon.
//
// Input channel (in_valid / in_stall) carries requests: a write request stores
// coord_x, coord_y at vertex_index and gives no result; a query request tests
// vertex_index as an ear and returns one result with is_ear, the doubled
// signed shoelace area and index_error. A two-entry request queue sits in
// front of the execution engine, so the sender is stalled only while it is full.
// Output channel (out_valid / out_stall) holds its result register while
// stalled; the engine waits for the register to free before retiring a query.
// The engine takes a new request only while idle: a write is stored on pop, and
// a query holds the engine until its result is retired. The single read port of
// the vertex store delivers one vertex a cycle to the sweep: three reads fetch
// the triangle, then every vertex is streamed once for the point tests and the
// area sum. Configuration registers are written through cfg_wr_en / cfg_index /
// cfg_data; the user must do so only while no request is in flight, and the
// block does not enforce it. Reset clears the registers, the queue and the
// engine; the vertex store keeps no reset and must be written before use.
module polygon_ear_test_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic [pet_pkg::VIDX_W-1:0]           vertex_index,
	input  logic signed [pet_pkg::COORD_BITS-1:0] coord_x,
	input  logic signed [pet_pkg::COORD_BITS-1:0] coord_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 is_ear,
	output logic signed [pet_pkg::AREA_W-1:0]    twice_area,
	output logic                                 index_error,
	input  logic                                 cfg_wr_en,
	input  logic [pet_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pet_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import pet_pkg::*;

	cfg_t cfg_q;
	req_t in_req;
	req_t q_req;
	logic q_valid;
	logic q_pop;

	// classify the incoming request
	assign in_req.kind = req_kind_t'(req_type);
	assign in_req.idx  = vertex_index;
	assign in_req.x    = coord_x;
	assign in_req.y    = coord_y;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_VERTEX_COUNT: cfg_q.count     <= cfg_data[CNT_W-1:0];
				CFG_CROSS_EPS:    cfg_q.cross_eps <= cfg_data[EPS_W-1:0];
				CFG_COORD_EPS:    cfg_q.coord_eps <= cfg_data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// accept and queue requests
	pet_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_req   (in_req),
		.q_valid  (q_valid),
		.q_req    (q_req),
		.q_pop    (q_pop)
	);

	// execute writes and queries against the vertex store
	pet_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_req       (q_req),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_ear      (is_ear),
		.twice_area  (twice_area),
		.index_error (index_error)
	);

	// a bad index never reports an ear
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_error |-> !is_ear)
		else $error("ear reported for an out-of-range index");

	// an empty polygon flags the index and has no area
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cfg_q.count == '0 |-> index_error && twice_area == '0)
		else $error("empty polygon result wrong");

	// the queue never pops while empty
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("request popped from empty queue");

endmodule
